// ===== rtl/pulse_peak_rate_averager_unit_assert.svh =====
// Assertion macros for the pulse peak rate averager.
// Used by the top level; the assertion bodies expect signals clk and rst in scope.
`ifndef PULSE_PEAK_RATE_AVERAGER_UNIT_ASSERT_SVH
`define PULSE_PEAK_RATE_AVERAGER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PPRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ppra assertion failed");
`define PPRA_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("ppra forbidden condition");
`else
`define PPRA_ASSERT(lbl, prop)
`define PPRA_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/ppra_pkg.sv =====
// Shared constants for the pulse peak rate averager.
// No dependencies; imported by the divider and the top level.
package ppra_pkg;

  localparam int AVG_DEPTH = 10;
  localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W     = 16 + FILL_W;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [DIV_NUM_W-1:0] RATE_NUM_Q8 = 24'd15360000;
  localparam logic [15:0]          RATE_MAX    = 16'hFFFF;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_AMP_LOW = 2'd0;
  localparam logic [1:0] REG_AMP_HIGH = 2'd1;
  localparam logic [1:0] REG_MIN_IVL = 2'd2;
  localparam logic [1:0] REG_MAX_IVL = 2'd3;

  localparam logic [18:0] AMP_LOW_RST  = 19'd50000;
  localparam logic [18:0] AMP_HIGH_RST = 19'd300000;
  localparam logic [15:0] MIN_IVL_RST  = 16'd300;
  localparam logic [15:0] MAX_IVL_RST  = 16'd1500;

endpackage

// ===== rtl/ppra_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ppra_pkg for operand widths.
module ppra_div import ppra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, quot[DIV_NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        quot <= num;
      end else if (busy) begin
        quot <= {quot[DIV_NUM_W-2:0], ge};
        rem  <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pulse_peak_rate_averager_unit.sv =====
// Pulse peak detector with beat rate averaging over a ring held in block memory.
// Depends on ppra_pkg, ppra_div and pulse_peak_rate_averager_unit_assert.svh.
//
// Input beat: ir_sample and time_ms on in_valid/in_ready. Output beat: beat_found
// and rate_avg_q8 on out_valid/out_ready, exactly one per input beat, in order.
// Registers (APB, 4-byte stride): amp_low, amp_high, min_interval_ms,
// max_interval_ms; write only while the block is idle.
// A sample that does not complete a beat has its result loaded into the output
// register at the same edge that accepts it; in_ready stays high, so such
// samples stream at one per cycle while the receiver keeps up.
// A sample that completes a beat runs the shared 24-step divider twice (rate,
// then average) and reads one ring entry per cycle to sum the filled entries
// of the 10-entry ring.
// When the receiver stalls, one more sample is taken and its result is parked;
// in_ready then drops until the output register frees up.
// Reset (synchronous) restores register defaults, clears peak state, ring
// pointer, fill count and the held average; ring contents are not cleared and
// are only read once written.
`include "pulse_peak_rate_averager_unit_assert.svh"

module pulse_peak_rate_averager_unit import ppra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [17:0]       ir_sample,
  input  logic [31:0]       time_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              beat_found,
  output logic [15:0]       rate_avg_q8,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {S_IDLE, S_RATE, S_SUM, S_AVG, S_DONE} state_t;

  state_t state;

  logic [18:0] amp_low;
  logic [18:0] amp_high;
  logic [15:0] min_ivl;
  logic [15:0] max_ivl;

  logic [17:0]       prev_amp;
  logic              falling;
  logic [31:0]       last_peak;
  logic [IDX_W-1:0]  wr_ptr;
  logic [FILL_W-1:0] fill;
  logic [15:0]       avg_hold;
  logic              pend_beat;

  logic [15:0]       ring [AVG_DEPTH];
  logic [15:0]       rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              issuing;
  logic              rd_vld;
  logic              rd_last;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;

  logic              accept;
  logic              out_free;
  logic              in_win;
  logic              rise;
  logic              drop;
  logic [31:0]       interval;
  logic              ivl_ok;
  logic              peak_beat;
  logic              idx_last;
  logic              ring_we;
  logic [15:0]       rate_sat;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_low  <= AMP_LOW_RST;
      amp_high <= AMP_HIGH_RST;
      min_ivl  <= MIN_IVL_RST;
      max_ivl  <= MAX_IVL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_AMP_LOW:  amp_low  <= pwdata[18:0];
        REG_AMP_HIGH: amp_high <= pwdata[18:0];
        REG_MIN_IVL:  min_ivl  <= pwdata[15:0];
        REG_MAX_IVL:  max_ivl  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AMP_LOW:  prdata = 32'(amp_low);
      REG_AMP_HIGH: prdata = 32'(amp_high);
      REG_MIN_IVL:  prdata = 32'(min_ivl);
      REG_MAX_IVL:  prdata = 32'(max_ivl);
      default:      prdata = '0;
    endcase
  end

  // peak detection on the incoming sample
  assign in_ready  = (state == S_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign in_win    = ({1'b0, ir_sample} > amp_low) && ({1'b0, ir_sample} < amp_high);
  assign rise      = ir_sample > prev_amp;
  assign drop      = (ir_sample < prev_amp) && !falling;
  assign interval  = time_ms - last_peak;
  assign ivl_ok    = (interval > 32'(min_ivl)) && (interval < 32'(max_ivl));
  assign peak_beat = in_win && !rise && drop && ivl_ok;

  assign rate_sat  = (div_quot[DIV_NUM_W-1:16] != '0) ? RATE_MAX : div_quot[15:0];
  assign ring_we   = (state == S_RATE) && div_done;
  assign idx_last  = ((FILL_W + 1)'(rd_idx) + 1'b1) == (FILL_W + 1)'(fill);
  assign sum_next  = sum + SUM_W'(rd_data);

  assign div_start = (accept && peak_beat) || ((state == S_SUM) && rd_vld && rd_last);
  assign div_num   = (state == S_IDLE) ? RATE_NUM_Q8 : DIV_NUM_W'(sum_next);
  assign div_den   = (state == S_IDLE) ? interval[DIV_DEN_W-1:0] : DIV_DEN_W'(fill);

  ppra_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // rate ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_ptr] <= rate_sat;
    end
    if (issuing) begin
      rd_data <= ring[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prev_amp  <= '0;
      falling   <= 1'b0;
      last_peak <= '0;
      wr_ptr    <= '0;
      fill      <= '0;
      avg_hold  <= '0;
      pend_beat <= 1'b0;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      rd_idx    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rd_vld  <= issuing;
      rd_last <= issuing && idx_last;
      case (state)
        S_IDLE: begin
          if (accept) begin
            prev_amp <= ir_sample;
            if (in_win) begin
              if (rise) begin
                falling <= 1'b0;
              end else if (drop) begin
                last_peak <= time_ms;
                falling   <= 1'b1;
              end
            end
            if (peak_beat) begin
              state <= S_RATE;
            end else if (out_free) begin
              out_valid   <= 1'b1;
              beat_found  <= 1'b0;
              rate_avg_q8 <= avg_hold;
            end else begin
              pend_beat <= 1'b0;
              state     <= S_DONE;
            end
          end
        end
        S_RATE: begin
          if (div_done) begin
            wr_ptr  <= (wr_ptr == IDX_W'(AVG_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
            if (fill != FILL_W'(AVG_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            sum     <= '0;
            rd_idx  <= '0;
            issuing <= 1'b1;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          if (issuing) begin
            if (idx_last) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (rd_vld) begin
            sum <= sum_next;
            if (rd_last) begin
              state <= S_AVG;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg_hold  <= div_quot[15:0];
            pend_beat <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            beat_found  <= pend_beat;
            rate_avg_q8 <= avg_hold;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PPRA_NEVER(a_fill_bound, fill > FILL_W'(AVG_DEPTH))
  `PPRA_ASSERT(a_div_done_state, div_done |-> (state == S_RATE || state == S_AVG))
  `PPRA_ASSERT(a_read_in_sum, issuing |-> state == S_SUM)
  `PPRA_ASSERT(a_stall_blocks, (accept && out_valid && !out_ready) |=> !in_ready)
  `PPRA_ASSERT(a_beat_rate_nonzero, (out_valid && beat_found) |-> rate_avg_q8 != 16'd0)

endmodule
